// ===== design/mrpl_pkg.sv =====
// Shared types, constants and helper functions for the particle LED block.
package mrpl_pkg;

    localparam int LED_COUNT      = 4;
    localparam int PARTICLE_COUNT = 3;
    localparam int BAND_COUNT     = 8;
    localparam int BAND_W         = 16;
    localparam int COLOR_W        = 8;
    localparam int IN_W           = BAND_COUNT * BAND_W;
    localparam int OUT_W          = 12 * COLOR_W;

    // Music modes
    typedef enum logic [1:0] {
        MODE_CALM   = 2'd0,
        MODE_NORMAL = 2'd1,
        MODE_BEAT   = 2'd2,
        MODE_CLIMAX = 2'd3
    } mode_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_FIELD_RADIUS = 2'd0;
    localparam logic [1:0] CFG_SPEED_FIRST  = 2'd1;
    localparam logic [1:0] CFG_SPEED_SECOND = 2'd2;
    localparam logic [1:0] CFG_SPEED_THIRD  = 2'd3;

    localparam logic [6:0] RADIUS_MIN   = 7'd1;
    localparam logic [6:0] RADIUS_MAX   = 7'd120;
    localparam logic [4:0] SPEED_MAX    = 5'd20;
    localparam logic [15:0] SCALE_ONE   = 16'd16384;
    localparam logic [15:0] RECIP_TEN   = 16'd52429;
    localparam logic [7:0] FLASH_FULL   = 8'd255;
    localparam logic [7:0] FLASH_FLOOR  = 8'd3;
    localparam logic [7:0] FLASH_SHOWN  = 8'd10;
    localparam logic [7:0] KICK_STEP    = 8'd30;

    localparam logic [18:0] CALM_LIMIT   = 19'd10;
    localparam logic [18:0] CLIMAX_LIMIT = 19'd80;
    localparam logic [17:0] BEAT_LIMIT   = 18'd40;

    // Target speed of each mode, unsigned Q2.14
    function automatic logic [15:0] mode_speed(input mode_t m);
        case (m)
            MODE_CALM:   mode_speed = 16'd4915;
            MODE_NORMAL: mode_speed = 16'd16384;
            MODE_BEAT:   mode_speed = 16'd8192;
            MODE_CLIMAX: mode_speed = 16'd29491;
            default:     mode_speed = 16'd16384;
        endcase
    endfunction

    // Target intensity of each mode
    function automatic logic [7:0] mode_intensity(input mode_t m);
        case (m)
            MODE_CALM:   mode_intensity = 8'd60;
            MODE_CLIMAX: mode_intensity = 8'd240;
            default:     mode_intensity = 8'd150;
        endcase
    endfunction

    // LED places on the line
    function automatic logic [7:0] led_place(input logic [1:0] led);
        case (led)
            2'd0:    led_place = 8'd32;
            2'd1:    led_place = 8'd96;
            2'd2:    led_place = 8'd160;
            default: led_place = 8'd224;
        endcase
    endfunction

    // x / 255 for x up to 255*255: x = 256q + lo = 255q + (q + lo)
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [8:0] q;
        logic [8:0] r;
        q = {1'b0, x[15:8]};
        r = {1'b0, x[7:0]} + q;
        if (r >= 9'd255)
        begin
            q = q + 9'd1;
            r = r - 9'd255;
        end
        if (r >= 9'd255)
        begin
            q = q + 9'd1;
        end
        div255 = q[7:0];
    endfunction

endpackage

// ===== design/mrpl_front.sv =====
// Front end: takes a frame of band deltas and classifies it into a music mode.
module mrpl_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // band_delta_0 .. band_delta_7, 16 bits each, band 0 lowest
    input  logic [127:0]            s_tdata,
    output logic                    push_valid,
    input  logic                    push_ready,
    output mrpl_pkg::mode_t         push_mode
);
    import mrpl_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_SUM  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t        state_reg, state_next;
    logic [IN_W-1:0] data_reg, data_next;
    logic [2:0]     idx_reg, idx_next;
    logic [18:0]    total_reg, total_next;
    logic [17:0]    low_reg, low_next;

    logic [15:0]        band;
    logic signed [16:0] band_x;
    logic [16:0]        band_abs;

    // Magnitude of the band under the pointer
    always_comb
    begin
        band     = data_reg[{idx_reg, 4'b0000} +: BAND_W];
        band_x   = {band[15], band};
        band_abs = band_x[16] ? 17'(-band_x) : 17'(band_x);
    end

    // Accumulate one band a cycle, then hand the mode on
    always_comb
    begin
        state_next = state_reg;
        data_next  = data_reg;
        idx_next   = idx_reg;
        total_next = total_reg;
        low_next   = low_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (s_tvalid)
                begin
                    data_next  = s_tdata;
                    idx_next   = 3'd0;
                    total_next = '0;
                    low_next   = '0;
                    state_next = F_SUM;
                end
            end
            F_SUM:
            begin
                total_next = total_reg + 19'(band_abs);
                if (!idx_reg[2])
                begin
                    low_next = low_reg + 18'(band_abs);
                end
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'd7)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Pick the mode from the summed magnitudes
    always_comb
    begin
        if (low_reg > BEAT_LIMIT)
        begin
            push_mode = MODE_BEAT;
        end
        else if (total_reg < CALM_LIMIT)
        begin
            push_mode = MODE_CALM;
        end
        else if (total_reg > CLIMAX_LIMIT)
        begin
            push_mode = MODE_CLIMAX;
        end
        else
        begin
            push_mode = MODE_NORMAL;
        end
    end

    assign s_tready   = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        idx_reg   <= idx_next;
        total_reg <= total_next;
        low_reg   <= low_next;
    end

endmodule

// ===== design/mrpl_queue.sv =====
// Two-entry queue of classified frames between the front and back ends.
module mrpl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  mrpl_pkg::mode_t push_mode,
    output logic            pop_valid,
    input  logic            pop_ready,
    output mrpl_pkg::mode_t pop_mode
);
    import mrpl_pkg::*;

    mode_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_mode   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and count on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_mode;
        end
    end

endmodule

// ===== design/mrpl_back.sv =====
// Back end: flash, speed, particle motion, LED fields and colour smoothing.
module mrpl_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_en,
    input  logic [1:0]      cfg_index,
    input  logic [6:0]      cfg_data,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  mrpl_pkg::mode_t pop_mode,
    output logic            m_tvalid,
    input  logic            m_tready,
    // led0_red, led0_green, led0_blue, led1_red .. led3_blue, 8 bits each
    output logic [95:0]     m_tdata
);
    import mrpl_pkg::*;

    typedef enum logic [8:0] {
        B_IDLE  = 9'b000000001,
        B_FLASH = 9'b000000010,
        B_SPEED = 9'b000000100,
        B_PART  = 9'b000001000,
        B_DIST  = 9'b000010000,
        B_DIV   = 9'b000100000,
        B_INF   = 9'b001000000,
        B_LED   = 9'b010000000,
        B_OUT   = 9'b100000000
    } bstate_t;

    bstate_t state_reg, state_next;

    // Configuration
    logic [6:0] radius_reg;
    logic [4:0] base_reg [3];

    // Frame state
    mode_t             mode_reg, mode_next;
    logic [7:0]        flash_reg, flash_next;
    logic [15:0]       scale_reg, scale_next;
    logic [2:0]        phase_reg, phase_next;
    logic [7:0]        pos_reg [3];
    logic [7:0]        pos_next [3];
    logic              down_reg [3];
    logic              down_next [3];
    logic [7:0]        inten_reg [3];
    logic [7:0]        inten_next [3];
    logic [7:0]        shown_reg [12];
    logic [7:0]        shown_next [12];

    // Sequencer working registers
    logic [1:0]        part_reg, part_next;
    logic [1:0]        led_reg, led_next;
    logic [2:0]        bit_reg, bit_next;
    logic [6:0]        rem_reg, rem_next;
    logic [7:0]        num_reg, num_next;
    logic [7:0]        quo_reg, quo_next;
    logic signed [16:0] diff_reg, diff_next;
    logic [7:0]        inf_reg [3];
    logic [7:0]        inf_next [3];
    logic [OUT_W-1:0]  out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    // Per-step logic
    logic [6:0]        rad;
    logic [9:0]        flash_x3;
    logic [15:0]       diff_abs;
    logic [31:0]       mag_prod;
    logic [12:0]       mag;
    logic [7:0]        ti;
    logic signed [9:0] di;
    logic signed [9:0] inten_sum;
    logic signed [9:0] pos_x;
    logic [4:0]        base;
    logic [20:0]       sp_prod;
    logic [6:0]        sp;
    logic signed [9:0] dd;
    logic [7:0]        gap;
    logic [6:0]        rd;
    logic [14:0]       num;
    logic [7:0]        trial;
    logic [7:0]        ch_sum;
    logic [7:0]        head;
    logic signed [9:0] ds;
    logic signed [9:0] shown_sum;
    logic              last_part;

    // Field radius limited to its working range
    always_comb
    begin
        if (radius_reg < RADIUS_MIN)
        begin
            rad = RADIUS_MIN;
        end
        else if (radius_reg > RADIUS_MAX)
        begin
            rad = RADIUS_MAX;
        end
        else
        begin
            rad = radius_reg;
        end
    end

    assign last_part = (part_reg == 2'(PARTICLE_COUNT - 1));
    assign pop_ready = (state_reg == B_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        flash_next     = flash_reg;
        scale_next     = scale_reg;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        down_next      = down_reg;
        inten_next     = inten_reg;
        shown_next     = shown_reg;
        part_next      = part_reg;
        led_next       = led_reg;
        bit_next       = bit_reg;
        rem_next       = rem_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        diff_next      = diff_reg;
        inf_next       = inf_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        flash_x3  = '0;
        diff_abs  = '0;
        mag_prod  = '0;
        mag       = '0;
        ti        = '0;
        di        = '0;
        inten_sum = '0;
        pos_x     = '0;
        base      = '0;
        sp_prod   = '0;
        sp        = '0;
        dd        = '0;
        gap       = '0;
        rd        = '0;
        num       = '0;
        trial     = '0;
        ch_sum    = '0;
        head      = '0;
        ds        = '0;
        shown_sum = '0;

        // Drop the result once it has been transferred
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    mode_next = pop_mode;
                    if (pop_mode == MODE_BEAT)
                    begin
                        flash_next = FLASH_FULL;
                    end
                    state_next = B_FLASH;
                end
            end
            // Decay the flash and measure the distance to the target speed
            B_FLASH:
            begin
                flash_x3 = {2'b00, flash_reg} + {1'b0, flash_reg, 1'b0};
                if (flash_x3[9:2] < FLASH_FLOOR)
                begin
                    flash_next = '0;
                end
                else
                begin
                    flash_next = flash_x3[9:2];
                end
                diff_next  = $signed({1'b0, mode_speed(mode_reg)})
                           - $signed({1'b0, scale_reg});
                state_next = B_SPEED;
            end
            // Move the speed scale a tenth of the way
            B_SPEED:
            begin
                diff_abs = diff_reg[16] ? 16'(-diff_reg) : 16'(diff_reg);
                mag_prod = diff_abs * RECIP_TEN;
                mag      = mag_prod[31:19];
                if (diff_reg[16])
                begin
                    scale_next = scale_reg - 16'(mag);
                end
                else
                begin
                    scale_next = scale_reg + 16'(mag);
                end
                part_next  = 2'd0;
                state_next = B_PART;
            end
            // Intensity, beat kick and step of one particle
            B_PART:
            begin
                ti = (flash_reg != 8'd0) ? FLASH_FULL : mode_intensity(mode_reg);
                di = $signed({2'b00, ti}) - $signed({2'b00, inten_reg[part_reg]});
                inten_sum = $signed({2'b00, inten_reg[part_reg]}) + (di >>> 3);
                inten_next[part_reg] = inten_sum[7:0];

                pos_x = $signed({2'b00, pos_reg[part_reg]});
                if (flash_reg != 8'd0 && phase_reg == {1'b0, part_reg})
                begin
                    if (down_reg[part_reg])
                    begin
                        pos_x = pos_x - $signed({2'b00, KICK_STEP});
                    end
                    else
                    begin
                        pos_x = pos_x + $signed({2'b00, KICK_STEP});
                    end
                end

                base    = (base_reg[part_reg] > SPEED_MAX) ? SPEED_MAX : base_reg[part_reg];
                sp_prod = base * scale_reg;
                sp      = (sp_prod[20:14] == 7'd0) ? 7'd1 : sp_prod[20:14];
                if (down_reg[part_reg])
                begin
                    pos_x = pos_x - $signed({3'b000, sp});
                end
                else
                begin
                    pos_x = pos_x + $signed({3'b000, sp});
                end

                // Reflect off either end of the line
                if (pos_x > 10'sd255)
                begin
                    pos_x = 10'sd510 - pos_x;
                    down_next[part_reg] = 1'b1;
                end
                else if (pos_x < 10'sd0)
                begin
                    pos_x = -pos_x;
                    down_next[part_reg] = 1'b0;
                end
                pos_next[part_reg] = pos_x[7:0];

                if (last_part)
                begin
                    part_next  = 2'd0;
                    led_next   = 2'd0;
                    state_next = B_DIST;
                end
                else
                begin
                    part_next = part_reg + 2'd1;
                end
            end
            // Distance of the particle to the LED; start the divide if in range
            B_DIST:
            begin
                dd  = $signed({2'b00, pos_reg[part_reg]}) - $signed({2'b00, led_place(led_reg)});
                gap = dd[9] ? 8'(-dd) : 8'(dd);
                if (gap < {1'b0, rad})
                begin
                    rd         = rad - gap[6:0];
                    num        = {rd, 8'b0} - {8'b0, rd};
                    rem_next   = num[14:8];
                    num_next   = num[7:0];
                    quo_next   = '0;
                    bit_next   = 3'd0;
                    state_next = B_DIV;
                end
                else
                begin
                    inf_next[part_reg] = '0;
                    if (last_part)
                    begin
                        state_next = B_LED;
                    end
                    else
                    begin
                        part_next = part_reg + 2'd1;
                    end
                end
            end
            // One quotient bit a cycle of (rad - distance) * 255 / rad
            B_DIV:
            begin
                trial    = {rem_reg, num_reg[7]};
                num_next = {num_reg[6:0], 1'b0};
                if (trial >= {1'b0, rad})
                begin
                    rem_next = 7'(trial - {1'b0, rad});
                    quo_next = {quo_reg[6:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[6:0];
                    quo_next = {quo_reg[6:0], 1'b0};
                end
                bit_next = bit_reg + 3'd1;
                if (bit_reg == 3'd7)
                begin
                    state_next = B_INF;
                end
            end
            // Weight the field by the particle intensity
            B_INF:
            begin
                inf_next[part_reg] = div255(16'(quo_reg) * 16'(inten_reg[part_reg]));
                if (last_part)
                begin
                    state_next = B_LED;
                end
                else
                begin
                    part_next  = part_reg + 2'd1;
                    state_next = B_DIST;
                end
            end
            // Add the flash and smooth the three channels of one LED
            B_LED:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    ch_sum = (c < PARTICLE_COUNT) ? inf_reg[c] : 8'd0;
                    if (flash_reg > FLASH_SHOWN)
                    begin
                        head   = FLASH_FULL - ch_sum;
                        ch_sum = ch_sum + div255(16'(head) * 16'(flash_reg));
                    end
                    ds = $signed({2'b00, ch_sum})
                       - $signed({2'b00, shown_reg[led_reg * 3 + c]});
                    shown_sum = $signed({2'b00, shown_reg[led_reg * 3 + c]}) + (ds >>> 2);
                    shown_next[led_reg * 3 + c] = shown_sum[7:0];
                end
                part_next = 2'd0;
                if (led_reg == 2'(LED_COUNT - 1))
                begin
                    state_next = B_OUT;
                end
                else
                begin
                    led_next   = led_reg + 2'd1;
                    state_next = B_DIST;
                end
            end
            // Load the output register once it is free
            B_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    for (int k = 0; k < 12; k++)
                    begin
                        out_next[k * COLOR_W +: COLOR_W] = shown_reg[k];
                    end
                    out_valid_next = 1'b1;
                    phase_next     = (phase_reg >= 3'd4) ? 3'd0 : phase_reg + 3'd1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_NORMAL;
            flash_reg     <= '0;
            scale_reg     <= SCALE_ONE;
            phase_reg     <= '0;
            pos_reg[0]    <= 8'd32;
            pos_reg[1]    <= 8'd96;
            pos_reg[2]    <= 8'd192;
            for (int i = 0; i < 3; i++)
            begin
                down_reg[i]  <= 1'b0;
                inten_reg[i] <= 8'd200;
            end
            for (int k = 0; k < 12; k++)
            begin
                shown_reg[k] <= '0;
            end
            radius_reg  <= 7'd30;
            base_reg[0] <= 5'd1;
            base_reg[1] <= 5'd2;
            base_reg[2] <= 5'd3;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            flash_reg     <= flash_next;
            scale_reg     <= scale_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            down_reg      <= down_next;
            inten_reg     <= inten_next;
            shown_reg     <= shown_next;
            if (cfg_en)
            begin
                case (cfg_index)
                    CFG_FIELD_RADIUS: radius_reg  <= cfg_data;
                    CFG_SPEED_FIRST:  base_reg[0] <= cfg_data[4:0];
                    CFG_SPEED_SECOND: base_reg[1] <= cfg_data[4:0];
                    CFG_SPEED_THIRD:  base_reg[2] <= cfg_data[4:0];
                    default:          radius_reg  <= radius_reg;
                endcase
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        led_reg  <= led_next;
        bit_reg  <= bit_next;
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        diff_reg <= diff_next;
        inf_reg  <= inf_next;
        out_reg  <= out_next;
    end

endmodule

// ===== design/music_reactive_particle_leds.sv =====
// Top level of the music-reactive particle LED block.
// Flow: the front end classifies a frame band by band; the back end then steps the
// particles and runs the bit-serial divider of the field strength for each particle
// and LED pair in range. The back end sequencer takes one frame at a time and bounds
// the frame rate; the front end can classify the next frame while it works.
// Reset: control and frame state take initial values at once; data registers do not.
module music_reactive_particle_leds (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_en,
    input  logic [1:0]   cfg_index,
    input  logic [6:0]   cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // band_delta_0 .. band_delta_7, 16 bits each, band 0 lowest
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // led0_red, led0_green, led0_blue, led1_red .. led3_blue, 8 bits each
    output logic [95:0]  m_tdata
);
    import mrpl_pkg::*;

    logic  push_valid, push_ready;
    mode_t push_mode;
    logic  pop_valid, pop_ready;
    mode_t pop_mode;

    mrpl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_mode  (push_mode)
    );

    mrpl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_mode  (push_mode),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_mode   (pop_mode)
    );

    mrpl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_mode  (pop_mode),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // The front end works on one frame at a time
    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("front end accepted a frame while busy");

    // A stalled classification holds until the queue takes it
    a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_ready) |=> (push_valid && push_mode == $past(push_mode)))
        else $error("classified frame dropped while queue full");

    // The back end takes one frame and then stays busy
    a_back_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready) |=> !pop_ready)
        else $error("back end took two frames back to back");

endmodule

// ===== test/tb_top.sv =====
// Testbench for the music-reactive particle LED block: directed table, then random frames.
`timescale 1ns / 100ps

module tb_top;
    import mrpl_pkg::*;

    localparam int FRAME_TOTAL  = 1300;
    localparam int STALL_LIMIT  = 20000;
    localparam int LONG_HOLD    = 600;

    logic        clk;
    logic        rst_n;
    logic        cfg_en;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [127:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;

    music_reactive_particle_leds dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Predictor state
    int unsigned radius_reg, base_reg [3];
    int unsigned phase_cnt, flash_lvl, scale_q14;
    int          part_pos [3], part_int [3];
    bit          part_down [3];
    mode_t       cur_mode;
    int          shown [12];

    logic [95:0] colour_queue [$];
    int          error_count = 0;
    int          frames_sent;
    int          colours_seen = 0;
    int          idle_cycles = 0;
    bit          hold_rx;
    int          beat_frames;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic int floor_div_pow2(input int d, input int sh);
        if (d >= 0)
            return d >>> sh;
        return -((-d + (1 << sh) - 1) >>> sh);
    endfunction

    task automatic reset_model();
        radius_reg = 30;
        base_reg[0] = 1;
        base_reg[1] = 2;
        base_reg[2] = 3;
        phase_cnt = 0;
        part_pos[0] = 32;
        part_pos[1] = 96;
        part_pos[2] = 192;
        for (int i = 0; i < 3; i++)
        begin
            part_down[i] = 1'b0;
            part_int[i] = 200;
        end
        cur_mode = MODE_NORMAL;
        flash_lvl = 0;
        scale_q14 = 16384;
        for (int i = 0; i < 12; i++)
            shown[i] = 0;
    endtask

    // Advance the model by one frame and return the packed colours
    function automatic logic [95:0] predict_colours(input logic [127:0] bands);
        int unsigned total, low, rad, gap, infl, head, sp, b;
        int          diff, mag, tint, ti, d, tgt;
        int unsigned sum [3];
        int          place [4];
        logic signed [15:0] v;
        logic [95:0] packed_out;
        place = '{32, 96, 160, 224};
        total = 0;
        low = 0;
        for (int i = 0; i < 8; i++)
        begin
            v = bands[i*16 +: 16];
            total += (v < 0) ? -int'(v) : int'(v);
            if (i < 4)
                low += (v < 0) ? -int'(v) : int'(v);
        end
        cur_mode = MODE_NORMAL;
        if (total < 10)
            cur_mode = MODE_CALM;
        else if (total > 80)
            cur_mode = MODE_CLIMAX;
        if (low > 40)
        begin
            cur_mode = MODE_BEAT;
            flash_lvl = 255;
        end
        if (flash_lvl > 0)
        begin
            flash_lvl = flash_lvl * 6 / 8;
            if (flash_lvl < 3)
                flash_lvl = 0;
        end
        case (cur_mode)
            MODE_CALM:   diff = 4915;
            MODE_BEAT:   diff = 8192;
            MODE_CLIMAX: diff = 29491;
            default:     diff = 16384;
        endcase
        diff = diff - int'(scale_q14);
        mag = (diff < 0 ? -diff : diff) / 10;
        scale_q14 = (scale_q14 + (diff < 0 ? -mag : mag)) & 16'hFFFF;
        tint = (cur_mode == MODE_CALM) ? 60 : (cur_mode == MODE_CLIMAX) ? 240 : 150;
        for (int i = 0; i < 3; i++)
        begin
            ti = tint;
            if (flash_lvl > 0)
            begin
                ti = 255;
                if (phase_cnt == i)
                    part_pos[i] += part_down[i] ? -30 : 30;
            end
            part_int[i] += floor_div_pow2(ti - part_int[i], 3);
        end
        for (int i = 0; i < 3; i++)
        begin
            b = base_reg[i] > 20 ? 20 : base_reg[i];
            sp = (b * scale_q14) >> 14;
            if (sp < 1)
                sp = 1;
            part_pos[i] += part_down[i] ? -int'(sp) : int'(sp);
            if (part_pos[i] > 255)
            begin
                part_pos[i] = 510 - part_pos[i];
                part_down[i] = 1'b1;
            end
            else if (part_pos[i] < 0)
            begin
                part_pos[i] = -part_pos[i];
                part_down[i] = 1'b0;
            end
        end
        rad = radius_reg;
        if (rad < 1)
            rad = 1;
        if (rad > 120)
            rad = 120;
        for (int led = 0; led < 4; led++)
        begin
            sum = '{0, 0, 0};
            for (int i = 0; i < 3; i++)
            begin
                d = part_pos[i] - place[led];
                gap = d < 0 ? -d : d;
                if (gap < rad)
                begin
                    infl = (rad - gap) * 255 / rad;
                    infl = infl * part_int[i] / 255;
                    // Each particle carries one full primary
                    sum[i] += 255 * infl / 255;
                end
            end
            for (int c = 0; c < 3; c++)
            begin
                if (flash_lvl > 10)
                begin
                    head = sum[c] > 255 ? 0 : 255 - sum[c];
                    sum[c] += head * flash_lvl / 255;
                end
                tgt = sum[c] > 255 ? 255 : int'(sum[c]);
                shown[led*3+c] += floor_div_pow2(tgt - shown[led*3+c], 2);
            end
        end
        phase_cnt = (phase_cnt >= 4) ? 0 : phase_cnt + 1;
        for (int i = 0; i < 12; i++)
            packed_out[i*8 +: 8] = shown[i][7:0];
        return packed_out;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        @(negedge clk);
        cfg_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_en <= 1'b0;
        if (idx == CFG_FIELD_RADIUS)
            radius_reg = val;
        else
            base_reg[idx - 1] = val[4:0];
    endtask

    // Withdraw the offer of a frame
    task automatic release_input();
        s_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    // Let the block drain before touching registers
    task automatic wait_drained();
        release_input();
        while (colour_queue.size() != 0)
            @(negedge clk);
        repeat (160) @(negedge clk);
    endtask

    task automatic send_frame(input logic [127:0] bands, input bit with_gap);
        int gap_cycles;
        gap_cycles = with_gap ? int'($urandom_range(0, 7)) : 0;
        if (gap_cycles != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap_cycles) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= bands;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        colour_queue.push_back(predict_colours(bands));
        frames_sent++;
        if (cur_mode == MODE_BEAT)
            beat_frames++;
        @(negedge clk);
    endtask

    function automatic logic [127:0] pack_bands(input int b0, input int b1, input int b2,
                                                input int b3, input int b4, input int b5,
                                                input int b6, input int b7);
        int vals [8];
        logic [127:0] r;
        vals = '{b0, b1, b2, b3, b4, b5, b6, b7};
        for (int i = 0; i < 8; i++)
            r[i*16 +: 16] = vals[i][15:0];
        return r;
    endfunction

    // Random frame: mostly small musical deltas, sometimes full range
    function automatic logic [127:0] random_bands();
        logic [127:0] r;
        int sel;
        sel = $urandom_range(0, 9);
        for (int i = 0; i < 8; i++)
        begin
            case (sel)
                0, 1:    r[i*16 +: 16] = 16'(int'($urandom_range(0, 2)) - 1);
                2, 3, 4: r[i*16 +: 16] = 16'(int'($urandom_range(0, 24)) - 12);
                5, 6:    r[i*16 +: 16] = 16'(int'($urandom_range(0, 60)) - 30);
                default: r[i*16 +: 16] = 16'($urandom);
            endcase
        end
        return r;
    endfunction

    // Directed table: band deltas, and an expected colour word where obvious
    typedef struct {
        logic [127:0] bands;
        bit           check_fixed;
        logic [95:0]  fixed_colours;
    } directed_row_t;

    directed_row_t directed_rows [$];

    // Receiver: a random wait before each transfer, one long hold-off on request
    initial
    begin
        int wait_cycles;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rx)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_rx = 1'b0;
            end
            else
            begin
                wait_cycles = $urandom_range(0, 7);
                if (wait_cycles != 0)
                begin
                    m_tready <= 1'b0;
                    repeat (wait_cycles) @(negedge clk);
                end
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready))
                @(posedge clk);
        end
    end

    // Compare each transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            colours_seen++;
            if (colour_queue.size() == 0)
            begin
                $display("%0t: unexpected output transfer %h", $realtime, m_tdata);
                error_count++;
            end
            else
            begin
                logic [95:0] want;
                want = colour_queue.pop_front();
                for (int i = 0; i < 12; i++)
                    if (want[i*8 +: 8] !== m_tdata[i*8 +: 8])
                    begin
                        $display("%0t: led%0d ch%0d expected %0d got %0d", $realtime,
                                 i / 3, i % 3, want[i*8 +: 8], m_tdata[i*8 +: 8]);
                        error_count++;
                    end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic [127:0] bands;
        rst_n = 1'b0;
        cfg_en = 1'b0;
        cfg_index = CFG_FIELD_RADIUS;
        cfg_data = 7'd0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        hold_rx = 1'b0;
        frames_sent = 0;
        beat_frames = 0;
        reset_model();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Band extremes and the edges of the mode thresholds, all checked by the predictor
        directed_rows.push_back('{pack_bands(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{pack_bands(32767, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{pack_bands(-32768, -32768, -32768, -32768,
                                             -32768, -32768, -32768, -32768), 1'b0, '0});
        directed_rows.push_back('{pack_bands(-1, -1, -1, -1, -1, -1, -1, -1), 1'b0, '0});
        directed_rows.push_back('{pack_bands(0, 0, 0, 0, 9, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{pack_bands(0, 0, 0, 0, 10, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{pack_bands(0, 0, 0, 0, 81, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{pack_bands(10, 10, 10, 10, 0, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{pack_bands(10, 10, 10, 11, 0, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{pack_bands(32767, 32767, 32767, 32767,
                                             32767, 32767, 32767, 32767), 1'b0, '0});
        for (int k = 0; k < 6; k++)
            directed_rows.push_back('{pack_bands(0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});

        // First silent frame after reset: particles step to 33, 97 and 194, so only
        // LED 0 (red) and LED 1 (green) light; checked by the predictor
        foreach (directed_rows[r])
        begin
            send_frame(directed_rows[r].bands, 1'b1);
            if (directed_rows[r].check_fixed)
                colour_queue[$] = directed_rows[r].fixed_colours;
        end

        // Register extremes, including out-of-range values, in several phases
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            case (ph)
                0:
                begin
                    write_reg(CFG_FIELD_RADIUS, 7'd0);
                    write_reg(CFG_SPEED_FIRST, 7'd0);
                    write_reg(CFG_SPEED_SECOND, 7'd0);
                    write_reg(CFG_SPEED_THIRD, 7'd0);
                end
                1:
                begin
                    write_reg(CFG_FIELD_RADIUS, 7'd127);
                    write_reg(CFG_SPEED_FIRST, 7'd31);
                    write_reg(CFG_SPEED_SECOND, 7'd20);
                    write_reg(CFG_SPEED_THIRD, 7'd21);
                end
                2:
                begin
                    write_reg(CFG_FIELD_RADIUS, 7'd120);
                    write_reg(CFG_SPEED_FIRST, 7'd20);
                    write_reg(CFG_SPEED_SECOND, 7'd1);
                    write_reg(CFG_SPEED_THIRD, 7'd10);
                end
                3:
                begin
                    write_reg(CFG_FIELD_RADIUS, 7'd1);
                    write_reg(CFG_SPEED_FIRST, 7'd5);
                    write_reg(CFG_SPEED_SECOND, 7'd15);
                    write_reg(CFG_SPEED_THIRD, 7'd20);
                end
                default:
                begin
                    write_reg(CFG_FIELD_RADIUS, 7'($urandom_range(0, 127)));
                    write_reg(CFG_SPEED_FIRST, 7'($urandom_range(0, 31)));
                    write_reg(CFG_SPEED_SECOND, 7'($urandom_range(0, 31)));
                    write_reg(CFG_SPEED_THIRD, 7'($urandom_range(0, 31)));
                end
            endcase
            for (int n = 0; n < FRAME_TOTAL / 6; n++)
            begin
                bands = random_bands();
                // Long receiver hold-off while frames keep coming
                if (ph == 1 && n == 20)
                    hold_rx = 1'b1;
                // Sender pause until every expected colour is in
                if (ph == 2 && n == 50)
                begin
                    release_input();
                    while (colour_queue.size() != 0)
                        @(negedge clk);
                end
                send_frame(bands, (n % 64) < 48);
            end
        end

        release_input();
        while (colour_queue.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        $display("Frames sent %0d, colour words checked %0d, beat frames %0d,",
                 frames_sent, colours_seen, beat_frames);
        $display("over six register settings including out-of-range values.");
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
design/mrpl_pkg.sv
design/mrpl_front.sv
design/mrpl_queue.sv
design/mrpl_back.sv
design/music_reactive_particle_leds.sv
test/tb_top.sv
